// File: src/clpe_pkg.sv
package clpe_pkg;

  localparam int CAPACITY = 32;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_DEL_HEAD  = 3'd3,
    FN_DEL_TAIL  = 3'd4,
    FN_DEL_POS   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_UNLINK,
    S_LINK1,
    S_LINK2,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    END_FRONT,
    END_BACK,
    END_MID
  } ins_end_t;

endpackage

// File: src/circular_list_positional_edit_core.sv
// Bounded circular doubly linked list of signed 32-bit words.
// Input channel (in_valid / in_stall): one item per edit, with in_func selecting
// insert front, insert back, insert at position, delete head, delete tail or
// delete at position; in_value and in_position carry the operands.
// Result channel (out_valid / out_stall): exactly one item per input item, with
// out_status, out_removed_value (zero unless an entry was deleted) and
// out_length, the entry count after the edit.
// One item is worked at a time by a small sequencer around the node memories
// (values, next links, prev links; one write and one registered read each per
// cycle). in_stall is high from acceptance until the result is loaded into the
// output register. Head and tail edits pass from decode to the unlink step or to
// the link steps, and then to done; positional edits first chase links from the
// head one node per cycle, so the link chase sets the rate.
// When the receiver stalls, the result holds in the output register; the
// block still takes the next item and finishes it once the register frees.
// Reset empties the list and refills the free-slot stack at once; no clearing
// pass is needed and an item may be offered in the first cycle after reset.
module circular_list_positional_edit_core import clpe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [5:0]         out_length
);

  state_t      state_r, state_nxt;
  logic [2:0]  func_r;
  logic [31:0] value_r;
  logic [7:0]  pos_r;
  cnt_t        count_r, count_nxt;
  slot_t       head_r, head_nxt;
  slot_t       tail_r, tail_nxt;
  slot_t       cur_r, cur_nxt;
  cnt_t        cnt_r, cnt_nxt;
  logic [7:0]  limit_r, limit_nxt;
  slot_t       slot_r, slot_nxt;
  slot_t       a_r, a_nxt;
  slot_t       b_r, b_nxt;
  ins_end_t    end_r, end_nxt;
  status_t     status_r, status_nxt;
  logic [31:0] removed_r, removed_nxt;
  slot_t       free_r [CAPACITY];

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r;
  logic [31:0] out_removed_r;
  logic [5:0]  out_length_r;
  logic        out_load;

  logic [31:0] val_mem  [CAPACITY];
  slot_t       next_mem [CAPACITY];
  slot_t       prev_mem [CAPACITY];
  logic [31:0] val_rd_r;
  slot_t       next_rd_r;
  slot_t       prev_rd_r;
  slot_t       rd_addr;

  logic        val_we;
  slot_t       val_wa;
  logic        next_we;
  slot_t       next_wa;
  slot_t       next_wd;
  logic        prev_we;
  slot_t       prev_wa;
  slot_t       prev_wd;
  logic        free_we;
  slot_t       free_wa;

  slot_t       free_top;
  slot_t       free_push;
  slot_t       free_slot;
  logic        walk_more;

  assign free_top  = slot_t'(cnt_t'(CAPACITY - 1) - count_r);
  assign free_push = slot_t'(cnt_t'(CAPACITY) - count_r);
  assign free_slot = free_r[free_top];
  assign walk_more = (CMP_W'(cnt_r) < CMP_W'(limit_r)) && (next_rd_r != head_r);

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_length        = out_length_r;

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= value_r;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    val_rd_r  <= val_mem[rd_addr];
    next_rd_r <= next_mem[rd_addr];
    prev_rd_r <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        free_r[i] <= slot_t'(i);
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      if (free_we) begin
        free_r[free_wa] <= cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r  <= in_func;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    cur_r     <= cur_nxt;
    cnt_r     <= cnt_nxt;
    limit_r   <= limit_nxt;
    slot_r    <= slot_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    end_r     <= end_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_removed_r <= removed_r;
      out_length_r  <= 6'(count_r);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    limit_nxt   = limit_r;
    slot_nxt    = slot_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    end_nxt     = end_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    rd_addr     = cur_r;
    val_we      = 1'b0;
    val_wa      = slot_r;
    next_we     = 1'b0;
    next_wa     = slot_r;
    next_wd     = b_r;
    prev_we     = 1'b0;
    prev_wa     = slot_r;
    prev_wd     = a_r;
    free_we     = 1'b0;
    free_wa     = free_push;
    out_load    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt  = ST_OK;
        removed_nxt = '0;
        case (func_r)
          FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
            if (count_r == cnt_t'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              slot_nxt = free_slot;
              a_nxt    = (count_r == '0) ? free_slot : tail_r;
              b_nxt    = (count_r == '0) ? free_slot : head_r;
              if (func_r == FN_INS_FRONT || (func_r == FN_INS_POS && pos_r <= 8'd1)) begin
                end_nxt   = END_FRONT;
                state_nxt = S_LINK1;
              end else if (func_r == FN_INS_BACK || count_r == '0) begin
                end_nxt   = END_BACK;
                state_nxt = S_LINK1;
              end else begin
                cur_nxt   = head_r;
                cnt_nxt   = cnt_t'(1);
                limit_nxt = pos_r - 8'd1;
                end_nxt   = END_MID;
                rd_addr   = head_r;
                state_nxt = S_WALK;
              end
            end
          end
          FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else if (func_r == FN_DEL_TAIL) begin
              cur_nxt   = tail_r;
              rd_addr   = tail_r;
              state_nxt = S_UNLINK;
            end else if (func_r == FN_DEL_HEAD || pos_r == 8'd1) begin
              cur_nxt   = head_r;
              rd_addr   = head_r;
              state_nxt = S_UNLINK;
            end else begin
              cur_nxt   = head_r;
              cnt_nxt   = cnt_t'(1);
              limit_nxt = pos_r;
              rd_addr   = head_r;
              state_nxt = S_WALK;
            end
          end
          default: begin
            status_nxt = ST_INVALID;
            state_nxt  = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        if (walk_more) begin
          cur_nxt = next_rd_r;
          cnt_nxt = cnt_r + cnt_t'(1);
          rd_addr = next_rd_r;
        end else if (func_r == FN_INS_POS) begin
          a_nxt     = cur_r;
          b_nxt     = next_rd_r;
          end_nxt   = (cur_r == tail_r) ? END_BACK : END_MID;
          state_nxt = S_LINK1;
        end else if (cur_r == head_r) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_UNLINK;
        end
      end

      S_UNLINK: begin
        next_we     = 1'b1;
        next_wa     = prev_rd_r;
        next_wd     = next_rd_r;
        prev_we     = 1'b1;
        prev_wa     = next_rd_r;
        prev_wd     = prev_rd_r;
        free_we     = 1'b1;
        removed_nxt = val_rd_r;
        count_nxt   = count_r - cnt_t'(1);
        if (count_r == cnt_t'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else begin
          if (cur_r == head_r) begin
            head_nxt = next_rd_r;
          end
          if (cur_r == tail_r) begin
            tail_nxt = prev_rd_r;
          end
        end
        state_nxt = S_DONE;
      end

      S_LINK1: begin
        val_we    = 1'b1;
        next_we   = 1'b1;
        prev_we   = 1'b1;
        state_nxt = S_LINK2;
      end

      S_LINK2: begin
        next_we   = 1'b1;
        next_wa   = a_r;
        next_wd   = slot_r;
        prev_we   = 1'b1;
        prev_wa   = b_r;
        prev_wd   = slot_r;
        count_nxt = count_r + cnt_t'(1);
        if (count_r == '0) begin
          head_nxt = slot_r;
          tail_nxt = slot_r;
        end else begin
          case (end_r)
            END_FRONT: head_nxt = slot_r;
            END_BACK:  tail_nxt = slot_r;
            default:   head_nxt = head_r;
          endcase
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_only_on_edit: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_LINK2 || state_r == S_UNLINK) |=> $stable(count_r))
    else $error("entry count changed outside an edit step");

  a_empty_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && status_r == ST_EMPTY) |-> count_r == '0)
    else $error("empty status with entries present");

  a_walk_within_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> (cnt_r <= count_r && cnt_r != '0))
    else $error("link chase ran past the list");
`endif

endmodule
